// ===== design/itoa_pkg.sv =====
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, constants and helpers for the integer to ASCII converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int unsigned NumWidth     = 64;
  localparam int unsigned DivBits      = 8;
  localparam int unsigned StepsPerDigit = NumWidth / DivBits;
  localparam int unsigned StepCntW     = $clog2(StepsPerDigit);
  localparam int unsigned StackDepth   = 64;
  localparam int unsigned StackAw      = $clog2(StackDepth);
  localparam int unsigned DigitCntW    = $clog2(StackDepth + 1);

  localparam logic [5:0] RadixMin    = 6'd2;
  localparam logic [5:0] RadixMax    = 6'd36;
  localparam logic [5:0] SignedRadix = 6'd10;
  localparam logic [5:0] DecimalLim  = 6'd10;

  localparam logic [7:0] CharZero      = 8'h30;
  localparam logic [7:0] CharNine      = 8'h39;
  localparam logic [7:0] CharLowA      = 8'h61;
  localparam logic [7:0] CharLowZ      = 8'h7a;
  localparam logic [7:0] CharAlphaBase = 8'h57;
  localparam logic [7:0] CharMinus     = 8'h2d;

  typedef enum logic [1:0] {
    OpU32 = 2'd0,
    OpU64 = 2'd1,
    OpS32 = 2'd2,
    OpS64 = 2'd3
  } opcode_e;

  typedef struct packed {
    logic [63:0] number_bits;
    logic [1:0]  opcode;
    logic [5:0]  radix;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } out_item_t;

  typedef struct packed {
    logic [NumWidth-1:0] mag;
    logic                neg;
    logic [5:0]          radix;
  } job_t;

  function automatic logic [7:0] digit_to_ascii(input logic [5:0] d);
    logic [7:0] c;
    if (d < DecimalLim) begin
      c = CharZero + {2'b00, d};
    end else begin
      c = CharAlphaBase + {2'b00, d};
    end
    return c;
  endfunction

endpackage

// ===== design/itoa_front.sv =====
// ----------------------------------------------------------------------------
// itoa_front
// Accepts input beats, resolves mode into magnitude, sign and radix, and
// holds classified jobs in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module itoa_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  itoa_pkg::in_item_t in_item_i,
  input  logic               job_take_i,
  output logic               job_valid_o,
  output itoa_pkg::job_t     job_o
);

  itoa_pkg::job_t job_d;
  logic [31:0]    low;
  logic [5:0]     sat_radix;

  itoa_pkg::job_t jobs_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q, cnt_d;
  logic           wr, rd;

  assign low = in_item_i.number_bits[31:0];

  always_comb begin
    if (in_item_i.radix < itoa_pkg::RadixMin) begin
      sat_radix = itoa_pkg::RadixMin;
    end else if (in_item_i.radix > itoa_pkg::RadixMax) begin
      sat_radix = itoa_pkg::RadixMax;
    end else begin
      sat_radix = in_item_i.radix;
    end
  end

  always_comb begin
    job_d.mag   = {32'd0, low};
    job_d.neg   = 1'b0;
    job_d.radix = sat_radix;
    case (itoa_pkg::opcode_e'(in_item_i.opcode))
      itoa_pkg::OpU32: begin
        job_d.mag = {32'd0, low};
      end
      itoa_pkg::OpU64: begin
        job_d.mag = in_item_i.number_bits;
      end
      itoa_pkg::OpS32: begin
        job_d.radix = itoa_pkg::SignedRadix;
        job_d.neg   = low[31];
        job_d.mag   = {32'd0, low[31] ? (~low + 32'd1) : low};
      end
      itoa_pkg::OpS64: begin
        job_d.radix = itoa_pkg::SignedRadix;
        job_d.neg   = in_item_i.number_bits[63];
        job_d.mag   = in_item_i.number_bits[63] ?
                      (~in_item_i.number_bits + 64'd1) : in_item_i.number_bits;
      end
      default: begin
        job_d.mag = {32'd0, low};
      end
    endcase
  end

  assign full        = (cnt_q == 2'd2);
  assign job_valid_o = (cnt_q != 2'd0);
  assign wr          = push && !full;
  assign rd          = job_take_i && job_valid_o;
  assign job_o       = jobs_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (wr && !rd) begin
      cnt_d = cnt_q + 2'd1;
    end else if (rd && !wr) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (wr) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (rd) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      jobs_q[wr_ptr_q] <= job_d;
    end
  end

endmodule

// ===== design/itoa_back.sv =====
// ----------------------------------------------------------------------------
// itoa_back
// Divides the magnitude by the radix one digit at a time, stacks the digits,
// then emits the sign and digits most significant first into an output queue.
// ----------------------------------------------------------------------------
module itoa_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  output logic                job_take_o,
  input  itoa_pkg::job_t      job_i,
  output logic                empty,
  input  logic                pop,
  output itoa_pkg::out_item_t out_item_o
);

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StDiv   = 5'b00010,
    StFetch = 5'b00100,
    StSign  = 5'b01000,
    StEmit  = 5'b10000
  } back_state_e;

  back_state_e state_q, state_d;

  logic [itoa_pkg::NumWidth-1:0]  num_q, num_d;
  logic [5:0]                     rem_q, rem_d;
  logic [5:0]                     radix_q;
  logic                           neg_q;
  logic [itoa_pkg::StepCntW-1:0]  step_q;
  logic [itoa_pkg::DigitCntW-1:0] nd_q;
  logic [5:0]                     stack_q [itoa_pkg::StackDepth];
  logic [5:0]                     top_q;
  logic [itoa_pkg::StackAw-1:0]   wr_addr, rd_addr;
  logic [6:0]                     trial;
  logic                           digit_done;
  logic                           stack_push, stack_pop;

  itoa_pkg::out_item_t oq_q [2];
  itoa_pkg::out_item_t beat;
  logic                oq_wr_ptr_q, oq_rd_ptr_q;
  logic [1:0]          oq_cnt_q, oq_cnt_d;
  logic                oq_full, oq_wr, oq_rd;

  always_comb begin
    rem_d = rem_q;
    num_d = num_q;
    trial = 7'd0;
    for (int i = 0; i < itoa_pkg::DivBits; i++) begin
      trial = {rem_d, num_d[itoa_pkg::NumWidth-1]};
      if (trial >= {1'b0, radix_q}) begin
        rem_d = 6'(trial - {1'b0, radix_q});
        num_d = {num_d[itoa_pkg::NumWidth-2:0], 1'b1};
      end else begin
        rem_d = trial[5:0];
        num_d = {num_d[itoa_pkg::NumWidth-2:0], 1'b0};
      end
    end
  end

  assign digit_done = (state_q == StDiv) &&
                      (step_q == itoa_pkg::StepCntW'(itoa_pkg::StepsPerDigit - 1));
  assign job_take_o = (state_q == StIdle) && job_valid_i;
  assign stack_push = digit_done;
  assign stack_pop  = (state_q == StEmit) && !oq_full;

  always_comb begin
    state_d         = state_q;
    oq_wr           = 1'b0;
    beat.char_code  = itoa_pkg::CharMinus;
    beat.last_char  = 1'b0;
    case (state_q)
      StIdle: begin
        if (job_valid_i) begin
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (digit_done && (num_d == '0)) begin
          state_d = StFetch;
        end
      end
      StFetch: begin
        state_d = neg_q ? StSign : StEmit;
      end
      StSign: begin
        if (!oq_full) begin
          oq_wr   = 1'b1;
          state_d = StEmit;
        end
      end
      StEmit: begin
        beat.char_code = itoa_pkg::digit_to_ascii(top_q);
        beat.last_char = (nd_q == itoa_pkg::DigitCntW'(1));
        if (!oq_full) begin
          oq_wr = 1'b1;
          if (nd_q == itoa_pkg::DigitCntW'(1)) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
      nd_q    <= '0;
    end else begin
      state_q <= state_d;
      if (job_take_o) begin
        step_q <= '0;
        nd_q   <= '0;
      end else begin
        if (state_q == StDiv) begin
          step_q <= step_q + itoa_pkg::StepCntW'(1);
        end
        if (stack_push) begin
          nd_q <= nd_q + itoa_pkg::DigitCntW'(1);
        end else if (stack_pop) begin
          nd_q <= nd_q - itoa_pkg::DigitCntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_take_o) begin
      num_q   <= job_i.mag;
      neg_q   <= job_i.neg;
      radix_q <= job_i.radix;
      rem_q   <= 6'd0;
    end else if (state_q == StDiv) begin
      num_q <= num_d;
      rem_q <= digit_done ? 6'd0 : rem_d;
    end
  end

  assign wr_addr = itoa_pkg::StackAw'(nd_q);
  assign rd_addr = stack_pop ? itoa_pkg::StackAw'(nd_q - itoa_pkg::DigitCntW'(2))
                             : itoa_pkg::StackAw'(nd_q - itoa_pkg::DigitCntW'(1));

  always_ff @(posedge clk_i) begin
    if (stack_push) begin
      stack_q[wr_addr] <= rem_d;
    end
    top_q <= stack_q[rd_addr];
  end

  assign oq_full    = (oq_cnt_q == 2'd2);
  assign empty      = (oq_cnt_q == 2'd0);
  assign oq_rd      = pop && !empty;
  assign out_item_o = oq_q[oq_rd_ptr_q];

  always_comb begin
    oq_cnt_d = oq_cnt_q;
    if (oq_wr && !oq_rd) begin
      oq_cnt_d = oq_cnt_q + 2'd1;
    end else if (oq_rd && !oq_wr) begin
      oq_cnt_d = oq_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_cnt_q    <= 2'd0;
      oq_wr_ptr_q <= 1'b0;
      oq_rd_ptr_q <= 1'b0;
    end else begin
      oq_cnt_q <= oq_cnt_d;
      if (oq_wr) begin
        oq_wr_ptr_q <= !oq_wr_ptr_q;
      end
      if (oq_rd) begin
        oq_rd_ptr_q <= !oq_rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_wr) begin
      oq_q[oq_wr_ptr_q] <= beat;
    end
  end

endmodule

// ===== design/integer_to_ascii_radix.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_radix
// Converts one integer per input beat into its ASCII text, one character per
// output beat, most significant character first.
//
//   channel  handshake      payload      direction
//   input    push / full    in_item_i    number_bits, opcode, radix
//   output   empty / pop    out_item_o   char_code, last_char
//
// The remainder unit retires 8 dividend bits per cycle; each item is taken,
// divided into digits, given a stack fetch, then emitted as an optional minus
// sign followed by its digits.
// Reset clears the queues and the sequencer; there is no clearing pass.
// A two-entry job queue lets the front take items while the back divides;
// a two-entry output queue holds characters while pop is low.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  itoa_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output itoa_pkg::out_item_t out_item_o
);

  logic           job_valid;
  logic           job_take;
  itoa_pkg::job_t job;

  itoa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .job_take_i  (job_take),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  itoa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_take_o  (job_take),
    .job_i       (job),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o)
  );

  a_take_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_take |-> job_valid)
    else $error("job taken while none queued");

  a_take_spaced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_take |=> !job_take)
    else $error("back end took two jobs in consecutive cycles");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.char_code == itoa_pkg::CharMinus) |-> !out_item_o.last_char)
    else $error("minus sign flagged as final character");

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.char_code == itoa_pkg::CharMinus) ||
               (out_item_o.char_code >= itoa_pkg::CharZero &&
                out_item_o.char_code <= itoa_pkg::CharNine) ||
               (out_item_o.char_code >= itoa_pkg::CharLowA &&
                out_item_o.char_code <= itoa_pkg::CharLowZ))
    else $error("character outside digit and sign set");

endmodule

// ===== tb/integer_to_ascii_radix_test.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_test
// Self-checking bench for the integer to ASCII converter. Numbers are pushed
// in all four modes, first as a directed set of edge values and radix corner
// cases, then at random. Each accepted number is expanded into its expected
// text by a scoreboard, and every popped character is checked against it.
// Both sides stall in random bursts; the tail of the run streams freely.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_test;

  import itoa_pkg::*;

  localparam int unsigned NumRandom   = 438;
  localparam int unsigned QuietTail   = 40;
  localparam int unsigned DrainCycles = 700;
  localparam int unsigned CycleLimit  = 3_000_000;

  class itoa_scoreboard;
    out_item_t   expected_chars[$];
    int unsigned mismatches;
    int unsigned chars_checked;
    int unsigned numbers_noted;
    int unsigned per_mode[4];

    function void flag_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) begin
        $display("MISMATCH: %s", msg);
      end
    endfunction

    function void note_number(in_item_t it);
      logic [63:0] bits;
      logic [63:0] mag;
      logic [63:0] base;
      logic [5:0]  digs [65];
      logic [5:0]  d;
      int          nd;
      bit          neg;
      bit          wide;
      opcode_e     op;
      out_item_t   ch;
      op   = opcode_e'(it.opcode);
      wide = (op == OpU64) || (op == OpS64);
      bits = it.number_bits;
      if (!wide) begin
        bits[63:32] = 32'd0;
      end
      neg = 1'b0;
      mag = bits;
      if (op == OpS32 || op == OpS64) begin
        base = {58'd0, SignedRadix};
        neg  = wide ? bits[63] : bits[31];
        if (neg) begin
          mag = ~bits + 64'd1;
          if (!wide) begin
            mag[63:32] = 32'd0;
          end
        end
      end else if (it.radix < RadixMin) begin
        base = {58'd0, RadixMin};
      end else if (it.radix > RadixMax) begin
        base = {58'd0, RadixMax};
      end else begin
        base = {58'd0, it.radix};
      end
      nd = 0;
      do begin
        digs[nd] = 6'(mag % base);
        nd++;
        mag = mag / base;
      end while (mag != 64'd0);
      if (neg) begin
        ch.char_code = CharMinus;
        ch.last_char = 1'b0;
        expected_chars.push_back(ch);
      end
      for (int i = nd - 1; i >= 0; i--) begin
        d = digs[i];
        ch.char_code = (d < 6'd10) ? CharZero + {2'b00, d} : CharLowA + {2'b00, d} - 8'd10;
        ch.last_char = (i == 0);
        expected_chars.push_back(ch);
      end
      numbers_noted++;
      per_mode[op]++;
    endfunction

    function void check_char(out_item_t got);
      out_item_t want;
      chars_checked++;
      if (expected_chars.size() == 0) begin
        flag_mismatch($sformatf("unexpected char 0x%02h last=%0b", got.char_code,
                                got.last_char));
        return;
      end
      want = expected_chars.pop_front();
      if (got.char_code !== want.char_code) begin
        flag_mismatch($sformatf("char %0d: char_code exp 0x%02h got 0x%02h", chars_checked,
                                want.char_code, got.char_code));
      end
      if (got.last_char !== want.last_char) begin
        flag_mismatch($sformatf("char %0d: last_char exp %0b got %0b", chars_checked,
                                want.last_char, got.last_char));
      end
    endfunction

    function int unsigned pending();
      return expected_chars.size();
    endfunction
  endclass

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        push      = 1'b0;
  logic        full;
  in_item_t    in_item   = '0;
  logic        empty;
  logic        pop       = 1'b0;
  out_item_t   out_item;
  int unsigned pop_hold  = 0;
  int unsigned cycle_cnt = 0;
  bit          quiet     = 1'b0;

  itoa_scoreboard sb;

  integer_to_ascii_radix i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // sample accepted beats on both sides
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        sb.note_number(in_item);
      end
      if (pop && !empty) begin
        sb.check_char(out_item);
      end
    end
  end

  // result side: hold pop low in random bursts
  always @(posedge clk_i) begin
    if (pop_hold != 0) begin
      pop      <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      pop      <= 1'b0;
      pop_hold <= $urandom_range(0, 6);
    end else begin
      pop <= 1'b1;
    end
  end

  function automatic in_item_t mk_item(logic [63:0] num, opcode_e op, logic [5:0] radix);
    in_item_t it;
    it.number_bits = num;
    it.opcode      = op;
    it.radix       = radix;
    return it;
  endfunction

  task automatic send_number(input in_item_t it);
    in_item <= it;
    push    <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic idle_input(input int unsigned n);
    push <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  initial begin
    in_item_t    directed[$];
    in_item_t    item;
    logic [63:0] num;
    sb = new();
    directed.push_back(mk_item(64'd0, OpU32, 6'd10));
    directed.push_back(mk_item(64'd0, OpU64, 6'd2));
    directed.push_back(mk_item(64'hFFFF_FFFF_0000_0000, OpS32, 6'd10));
    directed.push_back(mk_item(64'd0, OpS64, 6'd36));
    directed.push_back(mk_item(64'h0000_0000_FFFF_FFFF, OpU32, 6'd2));
    directed.push_back(mk_item(64'hFFFF_FFFF_FFFF_FFFF, OpU64, 6'd2));
    directed.push_back(mk_item(64'hFFFF_FFFF_FFFF_FFFF, OpU64, 6'd36));
    directed.push_back(mk_item(64'hDEAD_BEEF_0000_0000, OpU32, 6'd16));
    directed.push_back(mk_item(64'h0000_0000_8000_0000, OpS32, 6'd10));
    directed.push_back(mk_item(64'h1234_5678_FFFF_FFFF, OpS32, 6'd0));
    directed.push_back(mk_item(64'hFFFF_FFFF_7FFF_FFFF, OpS32, 6'd63));
    directed.push_back(mk_item(64'h8000_0000_0000_0000, OpS64, 6'd10));
    directed.push_back(mk_item(64'hFFFF_FFFF_FFFF_FFFF, OpS64, 6'd2));
    directed.push_back(mk_item(64'h7FFF_FFFF_FFFF_FFFF, OpS64, 6'd16));
    directed.push_back(mk_item(64'd35, OpU32, 6'd36));
    directed.push_back(mk_item(64'd1234, OpU64, 6'd0));
    directed.push_back(mk_item(64'd1234, OpU64, 6'd1));
    directed.push_back(mk_item(64'd1234, OpU64, 6'd37));
    directed.push_back(mk_item(64'hFFFF_FFFF_FFFF_FFFF, OpU64, 6'd63));
    directed.push_back(mk_item(64'h0000_0000_1234_5678, OpU32, 6'd16));
    directed.push_back(mk_item(64'hFFFF_FFFF_FFFF_CFC7, OpS32, 6'd16));
    directed.push_back(mk_item(64'd9, OpU64, 6'd10));
    directed.push_back(mk_item(64'd10, OpU32, 6'd11));
    directed.push_back(mk_item(64'h8000_0000_0000_0000, OpU64, 6'd8));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if ($urandom_range(0, 3) == 0) begin
        idle_input($urandom_range(1, 7));
      end
      send_number(directed[i]);
    end

    for (int n = 0; n < NumRandom; n++) begin
      if (n >= NumRandom - QuietTail) begin
        quiet = 1'b1;
      end
      case ($urandom_range(0, 3))
        0: num = {$urandom(), $urandom()};
        1: num = 64'($urandom_range(0, 999));
        2: num = {$urandom(), $urandom()} >> $urandom_range(0, 63);
        default: begin
          case ($urandom_range(0, 3))
            0: num = 64'hFFFF_FFFF_FFFF_FFFF;
            1: num = 64'h8000_0000_0000_0000 | 64'($urandom_range(0, 3));
            2: num = {$urandom(), 32'h8000_0000};
            default: num = {$urandom(), 32'h7FFF_FFFF};
          endcase
        end
      endcase
      item.number_bits = num;
      item.opcode      = opcode_e'($urandom_range(0, 3));
      item.radix       = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                                     : 6'($urandom_range(2, 36));
      if (!quiet && $urandom_range(0, 3) == 0) begin
        idle_input($urandom_range(1, 7));
      end
      send_number(item);
    end
    push <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Converted %0d numbers (u32 %0d, u64 %0d, s32 %0d, s64 %0d)", sb.numbers_noted,
             sb.per_mode[OpU32], sb.per_mode[OpU64], sb.per_mode[OpS32], sb.per_mode[OpS64]);
    $display("Checked %0d characters, %0d mismatches, %0d cycles", sb.chars_checked,
             sb.mismatches, cycle_cnt);
    if (sb.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
